// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define AAT_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define AAT_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/aat_pkg.sv -----
`default_nettype none

package aat_pkg;

   localparam int ADDR_W   = 32;
   localparam int LEN_W    = 32;
   localparam int LINE_W   = 24;
   localparam int INDEX_W  = 8;
   localparam int COUNT_W  = 7;
   localparam int REQ_BITS = 2 + ADDR_W + LEN_W + LINE_W + INDEX_W;
   localparam int RSP_BITS = 2 + ADDR_W + LEN_W + LINE_W + COUNT_W + 1;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   typedef enum logic [1:0] {
      OP_ADD  = 2'd0,
      OP_DEL  = 2'd1,
      OP_READ = 2'd2,
      OP_NOP  = 2'd3
   } op_type;

   typedef struct packed {
      logic [REQ_W-REQ_BITS-1:0] pad;
      logic [INDEX_W-1:0]        entry_index;
      logic [LINE_W-1:0]         source_line;
      logic [LEN_W-1:0]          block_length;
      logic [ADDR_W-1:0]         address;
      op_type                    command;
   } req_type;

   typedef struct packed {
      logic [RSP_W-RSP_BITS-1:0] pad;
      logic                      any_used;
      logic [COUNT_W-1:0]        used_count;
      logic [LINE_W-1:0]         entry_line;
      logic [LEN_W-1:0]          entry_length;
      logic [ADDR_W-1:0]         entry_base;
      logic                      entry_used;
      logic                      op_ok;
   } rsp_type;

   typedef struct packed {
      logic [LINE_W-1:0] line;
      logic [LEN_W-1:0]  length;
      logic [ADDR_W-1:0] base;
   } entry_type;

   // Controller to datapath.
   typedef struct packed {
      logic load;
      logic issue;
      logic out_load;
   } ctrl_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic done;
      logic exhausted;
      logic out_free;
   } ctrl_stat_type;

endpackage

`default_nettype wire

// ----- sv/aat_ctrl.sv -----
`default_nettype none

module aat_ctrl (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_tvalid,
   output logic                   req_tready,
   input  aat_pkg::ctrl_stat_type stat,
   output aat_pkg::ctrl_cmd_type  cmd
);
   import aat_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type state_ff;
   logic      ready_ff;

   assign req_tready = ready_ff;

   always_comb begin
      cmd.load     = req_tvalid && ready_ff;
      // Stop issuing reads as soon as the evaluated entry ends the operation.
      cmd.issue    = (state_ff == ST_SCAN) && !stat.exhausted && !stat.done;
      cmd.out_load = (state_ff == ST_FINISH) && stat.out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (cmd.load) begin
                  state_ff <= ST_SCAN;
                  ready_ff <= 1'b0;
               end
            end
            ST_SCAN: begin
               if (stat.done) begin
                  state_ff <= ST_FINISH;
               end
            end
            ST_FINISH: begin
               if (stat.out_free) begin
                  state_ff <= ST_IDLE;
                  ready_ff <= 1'b1;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
               ready_ff <= 1'b1;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

// ----- sv/aat_dpath.sv -----
`default_nettype none

module aat_dpath #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire                            clock,
   input  wire                            reset,
   input  wire  [aat_pkg::REQ_W-1:0]      req_tdata,
   input  aat_pkg::ctrl_cmd_type          cmd,
   output aat_pkg::ctrl_stat_type         stat,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [aat_pkg::RSP_W-1:0]      rsp_tdata
);
   import aat_pkg::*;

   localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int EW = (CW > COUNT_W) ? CW : COUNT_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

   req_type req;
   assign req = req_type'(req_tdata);

   // Operation registers, loaded on the input transfer.
   op_type            op_ff;
   logic [ADDR_W-1:0] addr_ff;
   logic [LEN_W-1:0]  len_ff;
   logic [LINE_W-1:0] line_ff;
   logic              in_range_ff;

   // Read issue stage.
   logic [IW-1:0] ptr_ff;
   logic          exh_ff;
   logic          is_scan;
   logic          issue_last;

   // Evaluation stage.
   logic          s2_vld_ff;
   logic          s2_used_ff;
   logic          s2_last_ff;
   logic [IW-1:0] s2_idx_ff;
   entry_type     q_ff;

   // Table storage.
   entry_type              mem [TABLE_DEPTH];
   logic [TABLE_DEPTH-1:0] used_ff;
   logic [CW-1:0]          count_ff;
   logic [CW-1:0]          count_in;
   logic [EW-1:0]          count_ext;

   logic    add_hit;
   logic    del_hit;
   logic    done;
   rsp_type res_in;
   rsp_type res_ff;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;

   assign is_scan    = (op_ff == OP_ADD) || (op_ff == OP_DEL);
   assign issue_last = is_scan ? (ptr_ff == LAST_IDX) : 1'b1;

   assign add_hit = (op_ff == OP_ADD) && !s2_used_ff;
   assign del_hit = (op_ff == OP_DEL) && s2_used_ff && (q_ff.base == addr_ff);
   assign done    = s2_vld_ff && (add_hit || del_hit || s2_last_ff);

   always_comb begin
      count_in = count_ff;
      if (done && add_hit) begin
         count_in = count_ff + CW'(1);
      end else if (done && del_hit) begin
         count_in = count_ff - CW'(1);
      end
   end

   assign count_ext = EW'(count_in);

   always_comb begin
      res_in = '0;
      res_in.used_count = (count_ext > EW'(COUNT_MAX)) ? COUNT_MAX : count_ext[COUNT_W-1:0];
      res_in.any_used   = (count_in != '0);
      if (op_ff == OP_READ) begin
         res_in.op_ok = in_range_ff;
         // An unused entry reads as zeros; its memory word may be stale, so it is not shown.
         if (in_range_ff && s2_used_ff) begin
            res_in.entry_used   = 1'b1;
            res_in.entry_base   = q_ff.base;
            res_in.entry_length = q_ff.length;
            res_in.entry_line   = q_ff.line;
         end
      end else begin
         res_in.op_ok = add_hit || del_hit;
      end
   end

   assign stat.done      = done;
   assign stat.exhausted = exh_ff;
   assign stat.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'(rsp_ff);

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff       <= req.command;
         addr_ff     <= req.address;
         len_ff      <= req.block_length;
         line_ff     <= req.source_line;
         in_range_ff <= (32'(req.entry_index) < TABLE_DEPTH);
         ptr_ff      <= (req.command == OP_READ) ? req.entry_index[IW-1:0] : '0;
      end else if (cmd.issue) begin
         ptr_ff <= ptr_ff + IW'(1);
      end
      if (cmd.issue) begin
         q_ff       <= mem[ptr_ff];
         s2_used_ff <= used_ff[ptr_ff];
         s2_idx_ff  <= ptr_ff;
         s2_last_ff <= issue_last;
      end
      if (done && add_hit) begin
         mem[s2_idx_ff] <= '{line: line_ff, length: len_ff, base: addr_ff};
      end
      if (done) begin
         res_ff <= res_in;
      end
      if (cmd.out_load) begin
         rsp_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exh_ff       <= 1'b0;
         s2_vld_ff    <= 1'b0;
         used_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_vld_ff <= cmd.issue;
         if (cmd.load) begin
            exh_ff <= 1'b0;
         end else if (cmd.issue && issue_last) begin
            exh_ff <= 1'b1;
         end
         if (done && add_hit) begin
            used_ff[s2_idx_ff] <= 1'b1;
         end else if (done && del_hit) begin
            used_ff[s2_idx_ff] <= 1'b0;
         end
         count_ff <= count_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

// ----- sv/allocation_tracking_table.sv -----
// Order: a read or an unknown command passes once through the read issue and evaluation
// stages; an add or a delete scans from entry 0, one entry per cycle, and stops at the
// first entry that qualifies, or after the last entry when none does.
// Flow: one operation is in flight at a time and the input is ready again as the
// result is loaded, which waits until the output register is free or being taken.
// Reset (synchronous): all used marks and the live count clear within the cycle.
`default_nettype none
`include "assert_macros.svh"

module allocation_tracking_table #(
   parameter int TABLE_DEPTH = 64
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_tvalid,
   output logic                       req_tready,
   // command[1:0], address[33:2], block_length[65:34], source_line[89:66],
   // entry_index[97:90], zero fill[103:98]
   input  wire  [aat_pkg::REQ_W-1:0]  req_tdata,
   output logic                       rsp_tvalid,
   input  wire                        rsp_tready,
   // op_ok[0], entry_used[1], entry_base[33:2], entry_length[65:34],
   // entry_line[89:66], used_count[96:90], any_used[97], zero fill[103:98]
   output logic [aat_pkg::RSP_W-1:0]  rsp_tdata
);
   import aat_pkg::*;

   ctrl_cmd_type  ctrl_cmd;
   ctrl_stat_type ctrl_stat;
   rsp_type       rsp_view;

   aat_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (ctrl_stat),
      .cmd        (ctrl_cmd)
   );

   aat_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (ctrl_cmd),
      .stat       (ctrl_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   assign rsp_view = rsp_type'(rsp_tdata);

   `AAT_ASSERT_IMP(a_leak_flag, rsp_tvalid,
                   rsp_view.any_used == (rsp_view.used_count != '0),
                   "any_used disagrees with used_count")
   `AAT_ASSERT_IMP(a_used_needs_ok, rsp_tvalid && rsp_view.entry_used, rsp_view.op_ok,
                   "entry_used without op_ok")
   `AAT_ASSERT_NXT(a_one_in_flight, req_tvalid && req_tready, !req_tready,
                   "second transfer taken while busy")
   `AAT_ASSERT_NXT(a_result_shown, ctrl_cmd.out_load, rsp_tvalid,
                   "loaded result not presented")

endmodule

`default_nettype wire

// ----- tb/sv/allocation_tracking_table_tb.sv -----
module allocation_tracking_table_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import aat_pkg::*;

   localparam int DEPTH      = 64;
   localparam int RAND_ITEMS = 1500;
   localparam int CHUNK      = 40;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   allocation_tracking_table #(
      .TABLE_DEPTH(DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #5 clock = ~clock;

   // Commands waiting to be sent and replies waiting to be seen.
   req_type cmd_backlog[$];
   rsp_type table_replies[$];

   // Bases that the generator believes are live, in table order of insertion.
   logic [ADDR_W-1:0] live_bases[$];

   // Table image kept by the predictor.
   logic              used_tab[DEPTH];
   logic [ADDR_W-1:0] base_tab[DEPTH];
   logic [LEN_W-1:0]  len_tab[DEPTH];
   logic [LINE_W-1:0] line_tab[DEPTH];
   int                live_total = 0;

   int errors       = 0;
   int total_items  = 0;
   int issued_count = 0;
   int seen_count   = 0;
   int send_idle_pct;
   int recv_idle_pct;

   initial begin
      for (int i = 0; i < DEPTH; i++) begin
         used_tab[i] = 1'b0;
         base_tab[i] = '0;
         len_tab[i]  = '0;
         line_tab[i] = '0;
      end
   end

   // The receiver idles more in the first third, the sender in the second,
   // and neither in the last.
   always_comb begin
      if (issued_count < total_items / 3) begin
         send_idle_pct = 34;
         recv_idle_pct = 58;
      end else if (issued_count < (2 * total_items) / 3) begin
         send_idle_pct = 58;
         recv_idle_pct = 34;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   end

   task automatic queue_request(op_type cmd, logic [ADDR_W-1:0] addr,
                                logic [LEN_W-1:0] len, logic [LINE_W-1:0] line,
                                logic [INDEX_W-1:0] idx);
      req_type r;
      r = '0;
      r.command      = cmd;
      r.address      = addr;
      r.block_length = len;
      r.source_line  = line;
      r.entry_index  = idx;
      cmd_backlog.push_back(r);
      if (cmd == OP_ADD && live_bases.size() < DEPTH) begin
         live_bases.push_back(addr);
      end else if (cmd == OP_DEL) begin
         for (int i = 0; i < live_bases.size(); i++) begin
            if (live_bases[i] == addr) begin
               live_bases.delete(i);
               break;
            end
         end
      end
   endtask

   function automatic rsp_type predict_table_op(req_type r);
      rsp_type p;
      logic    done;
      p    = '0;
      done = 1'b0;
      case (r.command)
         OP_ADD: begin
            for (int i = 0; i < DEPTH; i++) begin
               if (!done && !used_tab[i]) begin
                  used_tab[i] = 1'b1;
                  base_tab[i] = r.address;
                  len_tab[i]  = r.block_length;
                  line_tab[i] = r.source_line;
                  live_total++;
                  p.op_ok = 1'b1;
                  done    = 1'b1;
               end
            end
         end
         OP_DEL: begin
            for (int i = 0; i < DEPTH; i++) begin
               if (!done && used_tab[i] && base_tab[i] == r.address) begin
                  used_tab[i] = 1'b0;
                  base_tab[i] = '0;
                  len_tab[i]  = '0;
                  line_tab[i] = '0;
                  if (live_total > 0) live_total--;
                  p.op_ok = 1'b1;
                  done    = 1'b1;
               end
            end
         end
         OP_READ: begin
            if (int'(r.entry_index) < DEPTH) begin
               p.op_ok        = 1'b1;
               p.entry_used   = used_tab[r.entry_index];
               p.entry_base   = base_tab[r.entry_index];
               p.entry_length = len_tab[r.entry_index];
               p.entry_line   = line_tab[r.entry_index];
            end
         end
         default: begin
         end
      endcase
      p.used_count = (live_total > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(live_total);
      p.any_used   = (live_total != 0);
      return p;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else if (!req_tvalid || req_tready) begin
         if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= cmd_backlog.pop_front();
            issued_count <= issued_count + 1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            table_replies.push_back(predict_table_op(req_type'(req_tdata)));
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_type'(rsp_tdata);
            seen_count++;
            if (table_replies.size() == 0) begin
               $error("response transfer with no command outstanding");
               errors++;
            end else begin
               want = table_replies.pop_front();
               if (got.op_ok !== want.op_ok) begin
                  $error("op_ok: expected %0d, got %0d", want.op_ok, got.op_ok);
                  errors++;
               end
               if (got.entry_used !== want.entry_used) begin
                  $error("entry_used: expected %0d, got %0d", want.entry_used,
                         got.entry_used);
                  errors++;
               end
               if (got.entry_base !== want.entry_base) begin
                  $error("entry_base: expected %h, got %h", want.entry_base,
                         got.entry_base);
                  errors++;
               end
               if (got.entry_length !== want.entry_length) begin
                  $error("entry_length: expected %h, got %h", want.entry_length,
                         got.entry_length);
                  errors++;
               end
               if (got.entry_line !== want.entry_line) begin
                  $error("entry_line: expected %h, got %h", want.entry_line,
                         got.entry_line);
                  errors++;
               end
               if (got.used_count !== want.used_count) begin
                  $error("used_count: expected %0d, got %0d", want.used_count,
                         got.used_count);
                  errors++;
               end
               if (got.any_used !== want.any_used) begin
                  $error("any_used: expected %0d, got %0d", want.any_used,
                         got.any_used);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      int                 mode;
      int                 pick;
      logic [ADDR_W-1:0]  addr;

      // Empty table: read, no-op and a delete that cannot match.
      queue_request(OP_READ, '0, '0, '0, 8'd0);
      queue_request(OP_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 8'hFF);
      queue_request(OP_DEL, 32'h0000_0000, '0, '0, '0);
      // Field extremes, then a duplicated base.
      queue_request(OP_ADD, 32'h0000_0000, 32'h0000_0000, 24'h00_0000, '0);
      queue_request(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, '0);
      queue_request(OP_ADD, 32'h0000_1234, 32'h0000_0010, 24'h00_0007, '0);
      queue_request(OP_ADD, 32'h0000_1234, 32'h0000_0020, 24'h00_0009, '0);
      for (int i = 0; i < 4; i++) queue_request(OP_READ, '0, '0, '0, INDEX_W'(i));
      // The lower of the two duplicates goes first and its entry reads as zero.
      queue_request(OP_DEL, 32'h0000_1234, '0, '0, '0);
      queue_request(OP_READ, '0, '0, '0, 8'd2);
      queue_request(OP_READ, '0, '0, '0, 8'd3);
      queue_request(OP_ADD, 32'hA5A5_5A5A, 32'h5A5A_A5A5, 24'hA5_5A5A, '0);
      queue_request(OP_READ, '0, '0, '0, 8'd2);
      queue_request(OP_READ, '0, '0, '0, 8'd63);
      queue_request(OP_READ, '0, '0, '0, 8'd64);
      queue_request(OP_READ, '0, '0, '0, 8'd255);
      queue_request(OP_DEL, 32'hDEAD_BEEF, '0, '0, '0);
      queue_request(OP_NOP, '0, '0, '0, '0);
      // Fill the table and push two adds past full.
      while (live_bases.size() < DEPTH) begin
         queue_request(OP_ADD, $urandom, $urandom, LINE_W'($urandom), '0);
      end
      queue_request(OP_ADD, 32'h1111_1111, 32'h2222_2222, 24'h33_3333, '0);
      queue_request(OP_ADD, 32'h4444_4444, 32'h5555_5555, 24'h66_6666, '0);
      queue_request(OP_READ, '0, '0, '0, 8'd63);

      // Random part in chunks that lean toward filling, draining or a mix.
      for (int n = 0; n < RAND_ITEMS; n++) begin
         if (n % CHUNK == 0) mode = $urandom_range(2);
         pick = $urandom_range(99);
         if ((mode == 0 && pick < 65) || (mode == 1 && pick < 20) ||
             (mode == 2 && pick < 35)) begin
            if ($urandom_range(9) < 3) addr = 32'h0000_1000 + 32'($urandom_range(7)) * 16;
            else addr = $urandom;
            queue_request(OP_ADD, addr, $urandom, LINE_W'($urandom), INDEX_W'($urandom));
         end else if ((mode == 0 && pick < 85) || (mode == 1 && pick < 85) ||
                      (mode == 2 && pick < 70)) begin
            if (live_bases.size() != 0 && $urandom_range(9) < 8) begin
               addr = live_bases[$urandom_range(live_bases.size() - 1)];
            end else if ($urandom_range(1) == 0) begin
               addr = 32'h0000_1000 + 32'($urandom_range(7)) * 16;
            end else begin
               addr = $urandom;
            end
            queue_request(OP_DEL, addr, $urandom, LINE_W'($urandom), INDEX_W'($urandom));
         end else if (pick < 97) begin
            queue_request(OP_READ, $urandom, $urandom, LINE_W'($urandom),
                          ($urandom_range(9) < 8) ? INDEX_W'($urandom_range(DEPTH - 1))
                                                  : INDEX_W'($urandom));
         end else begin
            queue_request(OP_NOP, $urandom, $urandom, LINE_W'($urandom),
                          INDEX_W'($urandom));
         end
      end
      total_items = cmd_backlog.size();

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Every queued command must come back as exactly one response transfer.
      while (seen_count < total_items) begin
         @(posedge clock);
      end
      repeat (DEPTH + 8) @(posedge clock);
      if (errors == 0 && seen_count == total_items && table_replies.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/aat_pkg.sv
sv/aat_ctrl.sv
sv/aat_dpath.sv
sv/allocation_tracking_table.sv
tb/sv/allocation_tracking_table_tb.sv
